>>> rtl/held_key_table_assert.svh
// Assertion macros for the held key table.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef HELD_KEY_TABLE_ASSERT_SVH
`define HELD_KEY_TABLE_ASSERT_SVH

// Same-cycle implication.
`define HKT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("held_key_table: same-cycle check failed");

// Next-cycle implication.
`define HKT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("held_key_table: next-cycle check failed");

`endif

>>> rtl/hkt_pkg.sv
// Shared types and constants for the held key table.
// No dependencies.
`default_nettype none
package hkt_pkg;

  localparam int CODE_W    = 29;
  localparam int CMD_W     = 2;
  localparam int IDX_MAX_W = 6;

  localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  typedef struct packed {
    logic                 found;
    logic [IDX_MAX_W-1:0] found_idx;
    logic                 empty_found;
    logic [IDX_MAX_W-1:0] empty_idx;
  } scan_res_t;

endpackage
`default_nettype wire

>>> rtl/hkt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module hkt_ram #(
  parameter int WIDTH  = 29,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/hkt_scan.sv
// Slot compare and first-match / first-empty tracking for the held key table.
// Depends on hkt_pkg.
`default_nettype none
module hkt_scan (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         clear,
  input  wire logic                         cmp_en,
  input  wire logic [hkt_pkg::IDX_MAX_W-1:0] cmp_idx,
  input  wire logic [hkt_pkg::CODE_W-1:0]    rd_data,
  input  wire logic                         slot_live,
  input  wire logic [hkt_pkg::CODE_W-1:0]    code,
  output hkt_pkg::scan_res_t                res
);
  import hkt_pkg::*;

  scan_res_t res_r;
  scan_res_t res_nxt;
  logic      hit;

  assign hit = slot_live && (rd_data == code);

  always_comb begin
    res_nxt = res_r;
    if (clear) begin
      res_nxt = '0;
    end else if (cmp_en) begin
      if (hit && !res_r.found) begin
        res_nxt.found     = 1'b1;
        res_nxt.found_idx = cmp_idx;
      end
      if (!slot_live && !res_r.empty_found) begin
        res_nxt.empty_found = 1'b1;
        res_nxt.empty_idx   = cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

>>> rtl/held_key_table.sv
// Held key table: a small table of currently held key codes, one command per transaction.
// A transaction is taken when start is high and busy is low. The block then reads every
// slot of its code RAM in turn (one read a cycle, with registered read data), decides, and
// writes back at most once; the result appears on out_is_held / out_overflowed with
// out_valid high for exactly one cycle. The receiver cannot stall; busy drops in the cycle
// that the result is shown, so a new command can already be taken in that cycle. The scan
// of every slot through the single RAM read port sets how long a command takes. Per-slot
// valid flip-flops give an empty table right after reset, with no clearing pass. Key code 0
// is never held; command code 3 acts as a query.
// Depends on hkt_pkg, hkt_ram, hkt_scan and held_key_table_assert.svh.
`default_nettype none
module held_key_table #(
  parameter int TABLE_SLOTS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [hkt_pkg::CMD_W-1:0]   in_command,
  input  wire logic [hkt_pkg::CODE_W-1:0]  in_key_code,
  output logic                             out_valid,
  output logic                             out_is_held,
  output logic                             out_overflowed
);
  import hkt_pkg::*;

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [CMD_W-1:0]       cmd_r;
  logic [CODE_W-1:0]      code_r;
  logic [TABLE_SLOTS-1:0] live_r, live_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_held_r, out_held_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic                   accept;
  logic                   issue;
  logic                   is_press;
  logic                   is_release;
  logic                   commit;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [CODE_W-1:0]      rd_data;
  scan_res_t              scan_res;

  assign accept     = start && (state_r == ST_IDLE);
  assign issue      = (state_r == ST_SCAN) && (cnt_r < CNT_W'(TABLE_SLOTS));
  assign commit     = (state_r == ST_COMMIT);
  assign is_press   = (code_r != '0) && (cmd_r == CMD_PRESS);
  assign is_release = (code_r != '0) && (cmd_r == CMD_RELEASE);

  assign ram_we    = commit && is_press && !scan_res.found;
  assign ram_waddr = scan_res.empty_found ? scan_res.empty_idx[IDX_W-1:0] : '0;

  hkt_ram #(
    .WIDTH  (CODE_W),
    .DEPTH  (TABLE_SLOTS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (code_r),
    .re    (issue),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  hkt_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (accept),
    .cmp_en    (cmp_vld_r),
    .cmp_idx   (IDX_MAX_W'(cmp_idx_r)),
    .rd_data   (rd_data),
    .slot_live (live_r[cmp_idx_r]),
    .code      (code_r),
    .res       (scan_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmp_vld_nxt   = issue;
    cmp_idx_nxt   = cnt_r[IDX_W-1:0];
    live_nxt      = live_r;
    out_valid_nxt = 1'b0;
    out_held_nxt  = out_held_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_ovf_nxt   = 1'b0;
        if (is_press) begin
          out_held_nxt = 1'b1;
          if (!scan_res.found) begin
            if (scan_res.empty_found) begin
              live_nxt[scan_res.empty_idx[IDX_W-1:0]] = 1'b1;
            end else begin
              live_nxt    = '0;
              live_nxt[0] = 1'b1;
              out_ovf_nxt = 1'b1;
            end
          end
        end else if (is_release) begin
          out_held_nxt = 1'b0;
          if (scan_res.found) begin
            live_nxt[scan_res.found_idx[IDX_W-1:0]] = 1'b0;
          end
        end else begin
          out_held_nxt = scan_res.found;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      out_held_r  <= 1'b0;
      out_ovf_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
      out_held_r  <= out_held_nxt;
      out_ovf_r   <= out_ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    if (accept) begin
      cmd_r  <= in_command;
      code_r <= in_key_code;
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_is_held    = out_held_r;
  assign out_overflowed = out_ovf_r;

`include "held_key_table_assert.svh"

  `HKT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `HKT_ASSERT_NOW(a_result_idle, out_valid, !busy)
  `HKT_ASSERT_NOW(a_ovf_held, out_overflowed && out_valid, out_is_held)
  `HKT_ASSERT_NEXT(a_ovf_one_live, out_valid && out_overflowed, live_r == TABLE_SLOTS'(1))
  `HKT_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)

endmodule
`default_nettype wire
